FILE: src/exlex_pkg.sv
// Shared types, character codes and token field layout for the expression lexer.
// No dependencies; used by expression_lexer and its checker.
package exlex_pkg;

    localparam int LENGTH_BITS_DEF   = 8;
    localparam int POSITION_BITS_DEF = 16;

    // Token field widths and their places in m_tdata, lowest bit first.
    localparam int KIND_W    = 4;
    localparam int LEN_W     = 8;
    localparam int OFF_W     = 32;
    localparam int POS_W     = 16;
    localparam int KIND_LSB  = 0;
    localparam int LEN_LSB   = KIND_LSB + KIND_W;
    localparam int OFF_LSB   = LEN_LSB + LEN_W;
    localparam int LINE_LSB  = OFF_LSB + OFF_W;
    localparam int COL_LSB   = LINE_LSB + POS_W;
    localparam int TOKEN_W   = COL_LSB + POS_W;
    localparam int M_TDATA_W = ((TOKEN_W + 7) / 8) * 8;
    localparam int S_TDATA_W = 8;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    typedef enum logic [KIND_W-1:0] {
        KIND_NUMBER = 4'd0,
        KIND_IDENT  = 4'd1,
        KIND_MUL    = 4'd2,
        KIND_DIV    = 4'd3,
        KIND_AND    = 4'd4,
        KIND_SLL    = 4'd5,
        KIND_SRL    = 4'd6,
        KIND_SRA    = 4'd7,
        KIND_SUB    = 4'd8,
        KIND_ADD    = 4'd9,
        KIND_OR     = 4'd10,
        KIND_XOR    = 4'd11,
        KIND_ASSIGN = 4'd12,
        KIND_SEMI   = 4'd13,
        KIND_EOL    = 4'd14
    } token_kind_t;

    typedef struct packed {
        token_kind_t       kind;
        logic [LEN_W-1:0]  length;
        logic [OFF_W-1:0]  offset;
        logic [POS_W-1:0]  line;
        logic [POS_W-1:0]  column;
        logic              last;
    } token_t;

    typedef struct packed {
        logic        valid;
        token_kind_t kind;
    } single_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_ident_start(input logic [7:0] c);
        return (c == CH_UNDER) || ((c >= CH_UA) && (c <= CH_UZ)) ||
               ((c >= CH_LA) && (c <= CH_LZ));
    endfunction

    // Characters that form a one-byte token on their own.
    function automatic single_t single_kind(input logic [7:0] c);
        single_t r;
        r.valid = 1'b1;
        r.kind  = KIND_MUL;
        case (c)
            CH_STAR:  r.kind = KIND_MUL;
            CH_SLASH: r.kind = KIND_DIV;
            CH_AMP:   r.kind = KIND_AND;
            CH_MINUS: r.kind = KIND_SUB;
            CH_PLUS:  r.kind = KIND_ADD;
            CH_BAR:   r.kind = KIND_OR;
            CH_CARET: r.kind = KIND_XOR;
            CH_EQ:    r.kind = KIND_ASSIGN;
            CH_SEMI:  r.kind = KIND_SEMI;
            CH_NL:    r.kind = KIND_EOL;
            default:  r.valid = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: src/expression_lexer.sv
// A token is written into the token queue on the beat that completes it, then offered on m_.
// Throughput: one text byte per cycle while each byte yields at most one token and m_tready
// stays high; the token channel carries one token per cycle, so a byte that yields two tokens
// takes two output beats, absorbed by a four-entry token queue.
// Reset (aresetn low, synchronous): scanner idle, line and column 1, offset 0, queue empty.
// Depends on exlex_pkg.
module expression_lexer #(
    parameter int LENGTH_BITS   = exlex_pkg::LENGTH_BITS_DEF,
    parameter int POSITION_BITS = exlex_pkg::POSITION_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [exlex_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] text_byte
    input  logic                             s_tlast,   // end_of_text
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [3:0] token_kind, [11:4] token_length, [43:12] start_offset,
    // [59:44] line_number, [75:60] column_number, [79:76] zero
    output logic [exlex_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast    // last_of_run
);
    import exlex_pkg::*;

    typedef enum logic [5:0] {
        MODE_IDLE  = 6'b000001,
        MODE_NUM   = 6'b000010,
        MODE_IDENT = 6'b000100,
        MODE_LT    = 6'b001000,
        MODE_GT    = 6'b010000,
        MODE_GTGT  = 6'b100000
    } scan_mode_t;

    localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [OFF_W-1:0]         OFF_MAX = '1;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    scan_mode_t               mode_reg, mode_next, mode_after;
    logic [LENGTH_BITS-1:0]   pend_len_reg, pend_len_next;
    logic [OFF_W-1:0]         pend_off_reg, pend_off_next;
    logic [POSITION_BITS-1:0] pend_col_reg, pend_col_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [OFF_W-1:0]         off_reg, off_next;

    token_t                   fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    logic [7:0]               c;
    logic                     s_accept, m_accept;
    logic                     digit, ident_start, consumed;
    single_t                  sk;
    logic                     a_valid, b_valid, f_valid;
    token_kind_t              a_kind, f_kind;
    logic [LENGTH_BITS-1:0]   a_len, f_len;
    token_t                   tok_a, tok_b, tok_f, out0, out1;
    logic [1:0]               n_tok, n_push;
    token_t                   head;

    assign c           = s_tdata;
    assign s_accept    = s_tvalid && s_tready;
    assign m_accept    = m_tvalid && m_tready;
    assign digit       = is_digit(c);
    assign ident_start = is_ident_start(c);
    assign sk          = single_kind(c);

    always_comb begin
        mode_after    = mode_reg;
        consumed      = 1'b0;
        a_valid       = 1'b0;
        a_kind        = KIND_NUMBER;
        a_len         = pend_len_reg;
        pend_len_next = pend_len_reg;
        pend_off_next = pend_off_reg;
        pend_col_next = pend_col_reg;
        b_valid       = 1'b0;

        // First the byte is offered to whatever token is pending.
        unique case (mode_reg) inside
            MODE_NUM, MODE_IDENT: begin
                if (digit || (mode_reg == MODE_IDENT && ident_start)) begin
                    consumed = 1'b1;
                    if (pend_len_reg != LEN_MAX) begin
                        pend_len_next = pend_len_reg + LENGTH_BITS'(1);
                    end
                end else begin
                    a_valid    = 1'b1;
                    a_kind     = (mode_reg == MODE_NUM) ? KIND_NUMBER : KIND_IDENT;
                    mode_after = MODE_IDLE;
                end
            end
            MODE_LT: begin
                if (c == CH_LT) begin
                    a_valid  = 1'b1;
                    a_kind   = KIND_SLL;
                    a_len    = LENGTH_BITS'(2);
                    consumed = 1'b1;
                end
                mode_after = MODE_IDLE;
            end
            MODE_GT: begin
                if (c == CH_GT) begin
                    mode_after = MODE_GTGT;
                    consumed   = 1'b1;
                end else begin
                    mode_after = MODE_IDLE;
                end
            end
            MODE_GTGT: begin
                a_valid = 1'b1;
                if (c == CH_GT) begin
                    a_kind   = KIND_SRL;
                    a_len    = LENGTH_BITS'(3);
                    consumed = 1'b1;
                end else begin
                    a_kind = KIND_SRA;
                    a_len  = LENGTH_BITS'(2);
                end
                mode_after = MODE_IDLE;
            end
            default: mode_after = MODE_IDLE;
        endcase

        // A byte not taken by the pending token is scanned from scratch.
        if (!consumed) begin
            if (sk.valid) begin
                b_valid = 1'b1;
            end else if (c == CH_LT || c == CH_GT || digit || ident_start) begin
                if (c == CH_LT) begin
                    mode_after = MODE_LT;
                end else if (c == CH_GT) begin
                    mode_after = MODE_GT;
                end else if (digit) begin
                    mode_after = MODE_NUM;
                end else begin
                    mode_after = MODE_IDENT;
                end
                pend_len_next = LENGTH_BITS'(1);
                pend_off_next = off_reg;
                pend_col_next = col_reg;
            end
        end

        // End of text flushes numbers, identifiers and a waiting ">>".
        f_valid = s_tlast && (mode_after == MODE_NUM || mode_after == MODE_IDENT ||
                              mode_after == MODE_GTGT);
        f_kind  = (mode_after == MODE_NUM)   ? KIND_NUMBER :
                  (mode_after == MODE_IDENT) ? KIND_IDENT  : KIND_SRA;
        f_len   = (mode_after == MODE_GTGT) ? LENGTH_BITS'(2) : pend_len_next;
        mode_next = s_tlast ? MODE_IDLE : mode_after;

        off_next = (off_reg != OFF_MAX) ? off_reg + OFF_W'(1) : off_reg;
        col_next = (col_reg != POS_MAX) ? col_reg + POSITION_BITS'(1) : col_reg;
        line_next = line_reg;
        if (!consumed && c == CH_NL) begin
            line_next = (line_reg != POS_MAX) ? line_reg + POSITION_BITS'(1) : line_reg;
            col_next  = POSITION_BITS'(1);
        end
        if (s_tlast) begin
            line_next = POSITION_BITS'(1);
            col_next  = POSITION_BITS'(1);
            off_next  = '0;
        end
    end

    // Token records; lengths and positions are cut to the field widths.
    always_comb begin
        tok_a.kind   = a_kind;
        tok_a.length = LEN_W'(16'(a_len));
        tok_a.offset = pend_off_reg;
        tok_a.line   = POS_W'(32'(line_reg));
        tok_a.column = POS_W'(32'(pend_col_reg));
        tok_a.last   = 1'b0;

        tok_b.kind   = sk.kind;
        tok_b.length = LEN_W'(1);
        tok_b.offset = off_reg;
        tok_b.line   = POS_W'(32'(line_reg));
        tok_b.column = POS_W'(32'(col_reg));
        tok_b.last   = 1'b0;

        tok_f.kind   = f_kind;
        tok_f.length = LEN_W'(16'(f_len));
        tok_f.offset = pend_off_next;
        tok_f.line   = POS_W'(32'(line_reg));
        tok_f.column = POS_W'(32'(pend_col_next));
        tok_f.last   = 1'b0;

        out1 = b_valid ? tok_b : tok_f;
        if (a_valid) begin
            out0  = tok_a;
            n_tok = (b_valid || f_valid) ? 2'd2 : 2'd1;
        end else begin
            out0  = b_valid ? tok_b : tok_f;
            n_tok = (b_valid || f_valid) ? 2'd1 : 2'd0;
        end
        out0.last = (n_tok == 2'd1);
        out1.last = 1'b1;
        n_push    = s_accept ? n_tok : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            pend_len_reg <= '0;
            pend_off_reg <= '0;
            pend_col_reg <= POSITION_BITS'(1);
            line_reg     <= POSITION_BITS'(1);
            col_reg      <= POSITION_BITS'(1);
            off_reg      <= '0;
        end else if (s_accept) begin
            mode_reg     <= mode_next;
            pend_len_reg <= pend_len_next;
            pend_off_reg <= pend_off_next;
            pend_col_reg <= pend_col_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            off_reg      <= off_next;
        end
    end

    // Token queue: up to two entries written per beat, one read per cycle while m_tready is high.
    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            fifo_mem[wr_ptr_reg] <= out0;
        end
        if (n_push == 2'd2) begin
            fifo_mem[wr_ptr_reg + PTR_W'(1)] <= out1;
        end
    end

    assign cnt_next = cnt_reg + CNT_W'(n_push) - CNT_W'(m_accept);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_push);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(m_accept);
            cnt_reg    <= cnt_next;
        end
    end

    assign s_tready = (cnt_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign m_tvalid = (cnt_reg != '0);
    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tlast  = head.last;
    assign m_tdata  = {(M_TDATA_W - TOKEN_W)'(0), head.column, head.line, head.offset,
                       head.length, head.kind};

endmodule

FILE: src/exlex_checker.sv
// Port-level assertions for expression_lexer, attached by the bind below.
// Depends on exlex_pkg for the token field layout and kind codes.
module exlex_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic [exlex_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic                            m_tlast
);
    import exlex_pkg::*;

    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  length;

    assign kind   = m_tdata[KIND_LSB +: KIND_W];
    assign length = m_tdata[LEN_LSB +: LEN_W];

    // The token queue is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("token offered right after reset");

    // An empty queue always has room for the tokens of the next beat.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while no token is waiting");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled token beat changed");

    // Kinds are in range, and fixed-length operators carry their length.
    a_kind_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (kind <= KIND_EOL) &&
                     (kind != KIND_EOL || length == LEN_W'(1)) &&
                     (kind != KIND_SLL || length == LEN_W'(2)) &&
                     (kind != KIND_SRL || length == LEN_W'(3)) &&
                     (kind != KIND_SRA || length == LEN_W'(2)))
        else $error("token kind or length out of place");

endmodule

bind expression_lexer exlex_checker u_exlex_checker (.*);
